/* rtl/mlo_pkg.sv */
// Shared constants, types and helper functions for the mip chain layout calculator.
package mlo_pkg;

    localparam int OFFSET_BITS = 34;
    localparam int MAX_LEVELS  = 14;

    localparam int LVL_W      = 4;
    localparam int DIM_W      = 14;
    localparam int DEPTH_W    = 12;
    localparam int BPE_W      = 5;
    localparam int FACE_W     = 3;
    localparam int SLICE_W    = 11;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int MUL_B_W    = 14;

    localparam logic [OFFSET_BITS-1:0] OFS_MAX   = '1;
    localparam logic [LVL_W-1:0]       TOP_LEVEL = LVL_W'(MAX_LEVELS - 1);
    localparam logic [FACE_W-1:0]      CUBE_FACES = FACE_W'(6);

    localparam logic [KIND_W-1:0] KIND_FLAT   = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_VOLUME = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_CUBE   = KIND_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_WIDTH,
        REG_BASE_HEIGHT,
        REG_BASE_DEPTH,
        REG_LOD_LIMIT,
        REG_BPE,
        REG_COMPRESSED,
        REG_TARGET_KIND
    } cfg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0]   base_width;
        logic [DIM_W-1:0]   base_height;
        logic [DEPTH_W-1:0] base_depth;
        logic [LVL_W-1:0]   lod_limit;
        logic [BPE_W-1:0]   bytes_per_element;
        logic               is_compressed;
        logic [KIND_W-1:0]  target_kind;
    } cfg_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] byte_offset;
        logic [DIM_W-1:0]       level_width;
        logic [DIM_W-1:0]       level_height;
        logic [DEPTH_W-1:0]     level_depth;
        logic [OFFSET_BITS-1:0] total_size;
        logic                   bad_request;
    } result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } walk_status_t;

    // Size of a mip level: base size (zero read as one) shifted by the level, floor one.
    function automatic logic [DIM_W-1:0] shrink(input logic [DIM_W-1:0] base,
                                                input logic [LVL_W-1:0] lvl);
        logic [DIM_W-1:0] v;
        v = (base == '0) ? DIM_W'(1) : base;
        v = v >> lvl;
        return (v == '0) ? DIM_W'(1) : v;
    endfunction

    // One step down the chain: halve with a floor of one.
    function automatic logic [DIM_W-1:0] halve(input logic [DIM_W-1:0] v);
        return ((v >> 1) == '0) ? DIM_W'(1) : (v >> 1);
    endfunction

    // Row count of a level: compressed levels count blocks of four rows, at least one.
    function automatic logic [DIM_W-1:0] rows_of(input logic [DIM_W-1:0] h,
                                                 input logic comp);
        logic [DIM_W-1:0] r;
        r = h >> 2;
        if (comp)
        begin
            return (r == '0) ? DIM_W'(1) : r;
        end
        return h;
    endfunction

    function automatic logic [OFFSET_BITS-1:0] sat_add(input logic [OFFSET_BITS-1:0] a,
                                                       input logic [OFFSET_BITS-1:0] b);
        logic [OFFSET_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[OFFSET_BITS] ? OFS_MAX : s[OFFSET_BITS-1:0];
    endfunction

endpackage

/* rtl/mipmap_layout_offset_calc.sv */
// Top level of the mip chain layout calculator: ports, output register and checks.
//
// This block answers surface queries for a texture whose mip levels are packed back
// to back, level zero first. Program the base width, height and depth, the last
// level, the bytes per element, the compressed flag and the target kind through the
// configuration port while the block is idle; each query item then names a level,
// a face and a slice, and one result item comes back with the byte offset of that
// surface, the sizes of the level, the total buffer size and a flag for a bad
// request. Offsets and sizes saturate at the top of the 34-bit offset range. A
// query occupies the block while it walks every level from zero to the last level
// clamped to 13, all through the single shared multiplier: each level takes three
// multiplications (bytes per element times width, times rows, times faces or
// depth) and one saturating add into the running total, and the requested face or
// slice costs one more multiplication and add at the end. The result then moves
// into the output register. in_stall is high while a query is being worked on; a
// finished result waiting in the output register does not hold off the next
// query, which starts at once and only waits at its end if the previous result
// has still not been taken.
module mipmap_layout_offset_calc
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mlo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mlo_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [mlo_pkg::LVL_W-1:0]       req_level,
    input  logic [mlo_pkg::FACE_W-1:0]      req_face,
    input  logic [mlo_pkg::SLICE_W-1:0]     req_slice,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mlo_pkg::OFFSET_BITS-1:0] byte_offset,
    output logic [mlo_pkg::DIM_W-1:0]       level_width,
    output logic [mlo_pkg::DIM_W-1:0]       level_height,
    output logic [mlo_pkg::DEPTH_W-1:0]     level_depth,
    output logic [mlo_pkg::OFFSET_BITS-1:0] total_size,
    output logic                            bad_request
);
    import mlo_pkg::*;

    cfg_t         cfg;
    walk_status_t walk_status;
    result_t      walk_res;
    result_t      out_reg;
    logic         out_valid_reg, out_valid_next;
    logic         start;
    logic         take;

    mlo_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The walker takes a new query only when it has handed off the previous result.
    assign in_stall = walk_status.busy;
    assign start    = in_valid && !in_stall;

    // A finished result moves into the output register when it is empty or being read.
    assign take = walk_status.done && (!out_valid_reg || !out_stall);

    mlo_walker u_walker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .start     (start),
        .req_level (req_level),
        .req_face  (req_face),
        .req_slice (req_slice),
        .take      (take),
        .status    (walk_status),
        .res       (walk_res)
    );

    always_comb
    begin
        priority if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= walk_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign byte_offset  = out_reg.byte_offset;
    assign level_width  = out_reg.level_width;
    assign level_height = out_reg.level_height;
    assign level_depth  = out_reg.level_depth;
    assign total_size   = out_reg.total_size;
    assign bad_request  = out_reg.bad_request;

    // An accepted query must put the walker to work in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> walk_status.busy)
        else $error("query accepted but walker did not start");

    // A bad request always reports a zero offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_request) |-> (byte_offset == '0))
        else $error("bad request with nonzero offset");

    // A valid surface always lies inside the buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !bad_request) |-> (byte_offset <= total_size))
        else $error("surface offset beyond total size");

    // Level sizes never drop below one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((level_width != '0) && (level_height != '0) && (level_depth != '0)))
        else $error("zero level size reported");

endmodule

/* rtl/mlo_cfg_regs.sv */
// Configuration register file of the mip chain layout calculator.
module mlo_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mlo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mlo_pkg::CFG_DATA_W-1:0] cfg_data,
    output mlo_pkg::cfg_t                  cfg
);
    import mlo_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BASE_WIDTH:  cfg_next.base_width        = cfg_data[DIM_W-1:0];
                REG_BASE_HEIGHT: cfg_next.base_height       = cfg_data[DIM_W-1:0];
                REG_BASE_DEPTH:  cfg_next.base_depth        = cfg_data[DEPTH_W-1:0];
                REG_LOD_LIMIT:   cfg_next.lod_limit         = cfg_data[LVL_W-1:0];
                REG_BPE:         cfg_next.bytes_per_element = cfg_data[BPE_W-1:0];
                REG_COMPRESSED:  cfg_next.is_compressed     = cfg_data[0];
                REG_TARGET_KIND: cfg_next.target_kind       = cfg_data[KIND_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_width        <= DIM_W'(1);
            cfg_reg.base_height       <= DIM_W'(1);
            cfg_reg.base_depth        <= DEPTH_W'(1);
            cfg_reg.lod_limit         <= '0;
            cfg_reg.bytes_per_element <= BPE_W'(4);
            cfg_reg.is_compressed     <= 1'b0;
            cfg_reg.target_kind       <= KIND_FLAT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/mlo_sat_mul.sv */
// Shared saturating multiplier with a registered product.
module mlo_sat_mul
(
    input  logic                            clk,
    input  logic                            en,
    input  logic [mlo_pkg::OFFSET_BITS-1:0] a,
    input  logic [mlo_pkg::MUL_B_W-1:0]     b,
    output logic [mlo_pkg::OFFSET_BITS-1:0] p
);
    import mlo_pkg::*;

    logic [OFFSET_BITS+MUL_B_W-1:0] full;
    logic [OFFSET_BITS-1:0]         p_reg;
    logic [OFFSET_BITS-1:0]         p_next;

    assign full   = {{MUL_B_W{1'b0}}, a} * {{OFFSET_BITS{1'b0}}, b};
    // Any bit above the offset width means the product is past the limit.
    assign p_next = (full[OFFSET_BITS+MUL_B_W-1:OFFSET_BITS] != '0) ? OFS_MAX
                                                                     : full[OFFSET_BITS-1:0];
    assign p      = p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

endmodule

/* rtl/mlo_walker.sv */
// Sequencer that walks the mip chain and drives the shared multiplier.
module mlo_walker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  mlo_pkg::cfg_t               cfg,
    input  logic                        start,
    input  logic [mlo_pkg::LVL_W-1:0]   req_level,
    input  logic [mlo_pkg::FACE_W-1:0]  req_face,
    input  logic [mlo_pkg::SLICE_W-1:0] req_slice,
    input  logic                        take,
    output mlo_pkg::walk_status_t       status,
    output mlo_pkg::result_t            res
);
    import mlo_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_W,
        ST_MUL_R,
        ST_MUL_L,
        ST_ADD,
        ST_STEP,
        ST_OFS,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [LVL_W-1:0]       lvl_cnt_reg, lvl_cnt_next;
    logic [LVL_W-1:0]       top_reg, top_next;
    logic [LVL_W-1:0]       req_lvl_reg, req_lvl_next;
    logic [SLICE_W-1:0]     idx_reg, idx_next;
    logic                   bad_reg, bad_next;
    logic [DIM_W-1:0]       w_reg, w_next;
    logic [DIM_W-1:0]       h_reg, h_next;
    logic [DEPTH_W-1:0]     d_reg, d_next;
    logic [OFFSET_BITS-1:0] total_reg, total_next;
    logic [OFFSET_BITS-1:0] lvl_ofs_reg, lvl_ofs_next;
    logic [OFFSET_BITS-1:0] unit_reg, unit_next;
    logic [OFFSET_BITS-1:0] ofs_reg, ofs_next;
    logic [DIM_W-1:0]       res_w_reg, res_w_next;
    logic [DIM_W-1:0]       res_h_reg, res_h_next;
    logic [DEPTH_W-1:0]     res_d_reg, res_d_next;

    logic                   mul_en;
    logic [OFFSET_BITS-1:0] mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic [OFFSET_BITS-1:0] mul_p;

    logic                   is_cube;
    logic                   is_vol;
    logic [LVL_W-1:0]       top_now;
    logic [DEPTH_W-1:0]     req_depth;

    mlo_sat_mul u_mul
    (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign is_cube   = (cfg.target_kind == KIND_CUBE);
    assign is_vol    = (cfg.target_kind == KIND_VOLUME);
    assign top_now   = (cfg.lod_limit > TOP_LEVEL) ? TOP_LEVEL : cfg.lod_limit;
    assign req_depth = DEPTH_W'(shrink(DIM_W'(cfg.base_depth), req_level));

    always_comb
    begin
        state_next   = state_reg;
        lvl_cnt_next = lvl_cnt_reg;
        top_next     = top_reg;
        req_lvl_next = req_lvl_reg;
        idx_next     = idx_reg;
        bad_next     = bad_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        d_next       = d_reg;
        total_next   = total_reg;
        lvl_ofs_next = lvl_ofs_reg;
        unit_next    = unit_reg;
        ofs_next     = ofs_reg;
        res_w_next   = res_w_reg;
        res_h_next   = res_h_reg;
        res_d_next   = res_d_reg;
        mul_en       = 1'b0;
        mul_a        = mul_p;
        mul_b        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    top_next     = top_now;
                    lvl_cnt_next = '0;
                    req_lvl_next = req_level;
                    w_next       = shrink(cfg.base_width, '0);
                    h_next       = shrink(cfg.base_height, '0);
                    d_next       = DEPTH_W'(shrink(DIM_W'(cfg.base_depth), '0));
                    total_next   = '0;
                    lvl_ofs_next = '0;
                    unit_next    = '0;
                    res_w_next   = shrink(cfg.base_width, req_level);
                    res_h_next   = shrink(cfg.base_height, req_level);
                    res_d_next   = req_depth;
                    if (is_cube)
                    begin
                        idx_next = SLICE_W'(req_face);
                        bad_next = (req_level > top_now) || (req_face >= CUBE_FACES)
                                   || (req_slice != '0);
                    end
                    else if (is_vol)
                    begin
                        idx_next = req_slice;
                        bad_next = (req_level > top_now) || (req_face != '0)
                                   || (DEPTH_W'(req_slice) >= req_depth);
                    end
                    else
                    begin
                        idx_next = '0;
                        bad_next = (req_level > top_now) || (req_face != '0)
                                   || (req_slice != '0);
                    end
                    state_next = ST_MUL_W;
                end
            end
            ST_MUL_W:
            begin
                // Bytes per element first, so a zero there clears the product early.
                mul_en     = 1'b1;
                mul_a      = OFFSET_BITS'(cfg.bytes_per_element);
                mul_b      = w_reg;
                state_next = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                mul_en     = 1'b1;
                mul_b      = rows_of(h_reg, cfg.is_compressed);
                state_next = ST_MUL_L;
            end
            ST_MUL_L:
            begin
                mul_en = 1'b1;
                mul_b  = is_cube ? MUL_B_W'(CUBE_FACES) : MUL_B_W'(d_reg);
                if (lvl_cnt_reg == req_lvl_reg)
                begin
                    unit_next = mul_p;
                end
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                total_next = sat_add(total_reg, mul_p);
                if (lvl_cnt_reg == req_lvl_reg)
                begin
                    lvl_ofs_next = total_reg;
                end
                if (lvl_cnt_reg == top_reg)
                begin
                    state_next = ST_STEP;
                end
                else
                begin
                    lvl_cnt_next = lvl_cnt_reg + LVL_W'(1);
                    w_next       = halve(w_reg);
                    h_next       = halve(h_reg);
                    d_next       = DEPTH_W'(halve(DIM_W'(d_reg)));
                    state_next   = ST_MUL_W;
                end
            end
            ST_STEP:
            begin
                mul_en     = 1'b1;
                mul_a      = unit_reg;
                mul_b      = MUL_B_W'(idx_reg);
                state_next = ST_OFS;
            end
            ST_OFS:
            begin
                ofs_next   = bad_reg ? '0 : sat_add(lvl_ofs_reg, mul_p);
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            lvl_cnt_reg <= '0;
            top_reg     <= '0;
            req_lvl_reg <= '0;
            bad_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            lvl_cnt_reg <= lvl_cnt_next;
            top_reg     <= top_next;
            req_lvl_reg <= req_lvl_next;
            bad_reg     <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        w_reg       <= w_next;
        h_reg       <= h_next;
        d_reg       <= d_next;
        total_reg   <= total_next;
        lvl_ofs_reg <= lvl_ofs_next;
        unit_reg    <= unit_next;
        ofs_reg     <= ofs_next;
        res_w_reg   <= res_w_next;
        res_h_reg   <= res_h_next;
        res_d_reg   <= res_d_next;
    end

    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = (state_reg == ST_FINISH);

    assign res.byte_offset  = ofs_reg;
    assign res.level_width  = res_w_reg;
    assign res.level_height = res_h_reg;
    assign res.level_depth  = res_d_reg;
    assign res.total_size   = total_reg;
    assign res.bad_request  = bad_reg;

endmodule

/* tb/mipmap_layout_offset_calc_checker.sv */
// Checker for the mip chain layout calculator: tracks the registers, predicts and compares.
`timescale 1ns / 100ps
module mipmap_layout_offset_calc_checker
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [mlo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mlo_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [mlo_pkg::LVL_W-1:0]       req_level,
    input  logic [mlo_pkg::FACE_W-1:0]      req_face,
    input  logic [mlo_pkg::SLICE_W-1:0]     req_slice,

    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [mlo_pkg::OFFSET_BITS-1:0] byte_offset,
    input  logic [mlo_pkg::DIM_W-1:0]       level_width,
    input  logic [mlo_pkg::DIM_W-1:0]       level_height,
    input  logic [mlo_pkg::DEPTH_W-1:0]     level_depth,
    input  logic [mlo_pkg::OFFSET_BITS-1:0] total_size,
    input  logic                            bad_request,

    output int                              fail_count,
    output int                              pending_count
);
    import mlo_pkg::*;

    localparam logic [63:0] SIZE_CEILING = 64'(OFS_MAX);

    cfg_t    layout;
    result_t surface_q[$];
    int      results_seen;

    // Size of one mip level along one axis; a zero base reads as one.
    function automatic logic [DIM_W-1:0] mip_extent(input logic [DIM_W-1:0] base,
                                                    input int lvl);
        logic [DIM_W-1:0] v;
        v = (base == '0) ? DIM_W'(1) : base;
        v = v >> lvl;
        return (v == '0) ? DIM_W'(1) : v;
    endfunction

    function automatic logic [63:0] block_rows(input logic [DIM_W-1:0] h, input logic comp);
        if (comp)
        begin
            return (h < DIM_W'(4)) ? 64'd1 : 64'(h / DIM_W'(4));
        end
        return 64'(h);
    endfunction

    function automatic logic [63:0] saturate(input logic [63:0] v);
        return (v > SIZE_CEILING) ? SIZE_CEILING : v;
    endfunction

    function automatic result_t predict_surface(input cfg_t c,
                                                input logic [LVL_W-1:0] lvl,
                                                input logic [FACE_W-1:0] face,
                                                input logic [SLICE_W-1:0] slice);
        logic [LVL_W-1:0]   top;
        logic               cube;
        logic               volume;
        logic               bad;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [DEPTH_W-1:0] d;
        logic [63:0]        running;
        logic [63:0]        level_start;
        logic [63:0]        bytes;
        logic [63:0]        index;
        result_t            r;
        top = (c.lod_limit > TOP_LEVEL) ? TOP_LEVEL : c.lod_limit;
        cube = (c.target_kind == KIND_CUBE);
        volume = (c.target_kind == KIND_VOLUME);
        running = '0;
        level_start = '0;
        for (int l = 0; l <= int'(top); l++)
        begin
            w = mip_extent(c.base_width, l);
            h = mip_extent(c.base_height, l);
            d = DEPTH_W'(mip_extent(DIM_W'(c.base_depth), l));
            bytes = block_rows(h, c.is_compressed) * (cube ? 64'(CUBE_FACES) : 64'(d))
                    * 64'(w) * 64'(c.bytes_per_element);
            if (l == int'(lvl))
                level_start = running;
            running = saturate(running + saturate(bytes));
        end
        w = mip_extent(c.base_width, int'(lvl));
        h = mip_extent(c.base_height, int'(lvl));
        d = DEPTH_W'(mip_extent(DIM_W'(c.base_depth), int'(lvl)));
        bad = (lvl > top);
        if (cube)
            bad = bad || (face >= CUBE_FACES) || (slice != '0);
        else if (volume)
            bad = bad || (face != '0) || (DEPTH_W'(slice) >= d);
        else
            bad = bad || (face != '0) || (slice != '0);
        index = cube ? 64'(face) : (volume ? 64'(slice) : 64'd0);
        r.byte_offset = '0;
        if (!bad)
            r.byte_offset = OFFSET_BITS'(saturate(level_start + saturate(index
                            * block_rows(h, c.is_compressed) * 64'(w)
                            * 64'(c.bytes_per_element))));
        r.level_width = w;
        r.level_height = h;
        r.level_depth = d;
        r.total_size = OFFSET_BITS'(running);
        r.bad_request = bad;
        return r;
    endfunction

    task automatic note_failure(input string msg);
        $display("%0t ns  layout check: %s", $time, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            note_failure($sformatf("result %0d %s is %0d, expected %0d",
                                   results_seen, name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t expected;
        if (!rst_n)
        begin
            layout.base_width = DIM_W'(1);
            layout.base_height = DIM_W'(1);
            layout.base_depth = DEPTH_W'(1);
            layout.lod_limit = '0;
            layout.bytes_per_element = BPE_W'(4);
            layout.is_compressed = 1'b0;
            layout.target_kind = KIND_FLAT;
            surface_q.delete();
            results_seen = 0;
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (surface_q.size() == 0)
                    note_failure($sformatf("result %0d arrived with no query waiting",
                                           results_seen));
                else
                begin
                    expected = surface_q.pop_front();
                    compare_field("byte_offset", 64'(byte_offset),
                                  64'(expected.byte_offset));
                    compare_field("level_width", 64'(level_width),
                                  64'(expected.level_width));
                    compare_field("level_height", 64'(level_height),
                                  64'(expected.level_height));
                    compare_field("level_depth", 64'(level_depth),
                                  64'(expected.level_depth));
                    compare_field("total_size", 64'(total_size),
                                  64'(expected.total_size));
                    compare_field("bad_request", 64'(bad_request),
                                  64'(expected.bad_request));
                end
                results_seen++;
            end
            if (in_valid && !in_stall)
                surface_q.push_back(predict_surface(layout, req_level, req_face, req_slice));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BASE_WIDTH:  layout.base_width = cfg_data[DIM_W-1:0];
                    REG_BASE_HEIGHT: layout.base_height = cfg_data[DIM_W-1:0];
                    REG_BASE_DEPTH:  layout.base_depth = cfg_data[DEPTH_W-1:0];
                    REG_LOD_LIMIT:   layout.lod_limit = cfg_data[LVL_W-1:0];
                    REG_BPE:         layout.bytes_per_element = cfg_data[BPE_W-1:0];
                    REG_COMPRESSED:  layout.is_compressed = cfg_data[0];
                    REG_TARGET_KIND: layout.target_kind = cfg_data[KIND_W-1:0];
                    default:         ;
                endcase
            end
            pending_count = surface_q.size();
        end
    end

endmodule

/* tb/mipmap_layout_offset_calc_tb.sv */
// Testbench top for the mip chain layout calculator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module mipmap_layout_offset_calc_tb;
    import mlo_pkg::*;

    // Target kind 3 has no name in the package; the block treats it as a flat surface.
    localparam logic [KIND_W-1:0]    KIND_SPARE    = KIND_W'(3);
    // Register index 7 is not mapped to anything, so writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE     = CFG_IDX_W'(7);
    localparam int                   IDLE_PCT      = 18;
    localparam int                   RANDOM_PHASES = 12;
    localparam int                   PHASE_ITEMS   = 80;
    localparam int                   QUIET_PHASE   = 5;
    localparam int                   SETTLE_CYCLES = 80;

    logic                   clk;
    logic                   rst_n;

    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    logic                   in_valid;
    logic                   in_stall;
    logic [LVL_W-1:0]       req_level;
    logic [FACE_W-1:0]      req_face;
    logic [SLICE_W-1:0]     req_slice;

    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [OFFSET_BITS-1:0] byte_offset;
    logic [DIM_W-1:0]       level_width;
    logic [DIM_W-1:0]       level_height;
    logic [DEPTH_W-1:0]     level_depth;
    logic [OFFSET_BITS-1:0] total_size;
    logic                   bad_request;

    int                     fail_count;
    int                     pending_count;

    // Idle rate shared by both channels; it drops to zero for one whole phase so that
    // there is a long stretch where the block runs back to back.
    int                     idle_pct = IDLE_PCT;
    int                     stall_left = 0;

    // What the stimulus needs to know about the current layout to build legal queries.
    logic [LVL_W-1:0]       cur_last = '0;
    logic [KIND_W-1:0]      cur_kind = KIND_FLAT;
    logic [DEPTH_W-1:0]     cur_depth = DEPTH_W'(1);

    mipmap_layout_offset_calc dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_level    (req_level),
        .req_face     (req_face),
        .req_slice    (req_slice),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_offset  (byte_offset),
        .level_width  (level_width),
        .level_height (level_height),
        .level_depth  (level_depth),
        .total_size   (total_size),
        .bad_request  (bad_request)
    );

    mipmap_layout_offset_calc_checker layout_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_level     (req_level),
        .req_face      (req_face),
        .req_slice     (req_slice),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .byte_offset   (byte_offset),
        .level_width   (level_width),
        .level_height  (level_height),
        .level_depth   (level_depth),
        .total_size    (total_size),
        .bad_request   (bad_request),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result back-pressure. About one stall in ten is a long one, so that the next
    // result can finish while the previous one is still held in the output register.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 599) < idle_pct)
        begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 3);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Drives one register write and returns at the edge that takes it, leaving valid
    // high so that back-to-back writes never lower and raise it in the same step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Writes every register. The values are full-width data words so that bits above
    // a register's own width still reach the port and must be dropped by the block.
    task automatic load_layout(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                               input logic [CFG_DATA_W-1:0] d,
                               input logic [CFG_DATA_W-1:0] last,
                               input logic [CFG_DATA_W-1:0] bpe,
                               input logic [CFG_DATA_W-1:0] comp,
                               input logic [CFG_DATA_W-1:0] kind, input logic spare);
        write_reg(REG_BASE_WIDTH, w);
        write_reg(REG_BASE_HEIGHT, h);
        write_reg(REG_BASE_DEPTH, d);
        write_reg(REG_LOD_LIMIT, last);
        write_reg(REG_BPE, bpe);
        write_reg(REG_COMPRESSED, comp);
        write_reg(REG_TARGET_KIND, kind);
        if (spare)
            write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_last = (last[LVL_W-1:0] > TOP_LEVEL) ? TOP_LEVEL : last[LVL_W-1:0];
        cur_kind = kind[KIND_W-1:0];
        cur_depth = d[DEPTH_W-1:0];
    endtask

    // Offers one query item and returns at the edge that accepts it. Valid stays high
    // afterwards; the next query or the drain decides at the following falling edge.
    task automatic send_query(input logic [LVL_W-1:0] lvl, input logic [FACE_W-1:0] face,
                              input logic [SLICE_W-1:0] slice);
        @(negedge clk);
        if ($urandom_range(0, 99) < 2 * idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 60))
                @(negedge clk);
        end
        in_valid <= 1'b1;
        req_level <= lvl;
        req_face <= face;
        req_slice <= slice;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stops offering queries and waits until every expected result has been taken.
    // Every query yields exactly one result, so the block is idle from then on.
    task automatic drain_queries();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // Sizes are drawn on a rough log scale so that small and large chains both occur.
    // One layout in four uses raw random data words for every register instead.
    task automatic random_layout();
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;
        logic [CFG_DATA_W-1:0] d;
        logic [CFG_DATA_W-1:0] last;
        logic [CFG_DATA_W-1:0] bpe;
        logic [CFG_DATA_W-1:0] comp;
        logic [CFG_DATA_W-1:0] kind;
        if ($urandom_range(0, 3) == 0)
        begin
            w = CFG_DATA_W'($urandom);
            h = CFG_DATA_W'($urandom);
            d = CFG_DATA_W'($urandom);
            last = CFG_DATA_W'($urandom);
            bpe = CFG_DATA_W'($urandom);
            comp = CFG_DATA_W'($urandom);
            kind = CFG_DATA_W'($urandom);
        end
        else
        begin
            w = CFG_DATA_W'($urandom_range(0, 16383) >> $urandom_range(0, 14));
            h = CFG_DATA_W'($urandom_range(0, 16383) >> $urandom_range(0, 14));
            d = CFG_DATA_W'($urandom_range(0, 4095) >> $urandom_range(0, 12));
            last = CFG_DATA_W'($urandom_range(0, 15));
            bpe = CFG_DATA_W'($urandom_range(0, 31));
            comp = CFG_DATA_W'($urandom_range(0, 1));
            kind = CFG_DATA_W'($urandom_range(0, 3));
        end
        load_layout(w, h, d, last, bpe, comp, kind, $urandom_range(0, 3) == 0);
    endtask

    // Most queries are legal for the current layout: a level that exists, a face
    // for a cube, a slice within the level's depth for a volume. The rest are raw
    // random fields, which mostly land on the bad request paths.
    task automatic random_query();
        logic [LVL_W-1:0]   lvl;
        logic [FACE_W-1:0]  face;
        logic [SLICE_W-1:0] slice;
        logic [DEPTH_W-1:0] lvl_depth;
        if ($urandom_range(0, 99) < 78)
        begin
            lvl = LVL_W'($urandom_range(0, cur_last));
            face = '0;
            slice = '0;
            if (cur_kind == KIND_CUBE)
                face = FACE_W'($urandom_range(0, CUBE_FACES - 1));
            else if (cur_kind == KIND_VOLUME)
            begin
                lvl_depth = ((cur_depth == '0) ? DEPTH_W'(1) : cur_depth) >> lvl;
                if (lvl_depth == '0)
                    lvl_depth = DEPTH_W'(1);
                slice = SLICE_W'($urandom_range(0, (lvl_depth > DEPTH_W'(2048)) ? 2047
                                                    : int'(lvl_depth) - 1));
            end
        end
        else
            {lvl, face, slice} = (LVL_W + FACE_W + SLICE_W)'($urandom);
        send_query(lvl, face, slice);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        req_level = '0;
        req_face = '0;
        req_slice = '0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Straight out of reset the texture is a single flat 1x1 level at four bytes
        // per element; anything but level 0, face 0, slice 0 is a bad request.
        send_query(4'd0, 3'd0, 11'd0);
        send_query(4'd1, 3'd0, 11'd0);
        send_query(4'd0, 3'd1, 11'd0);
        send_query(4'd0, 3'd0, 11'd1);
        drain_queries();

        // Full fourteen-level cube chain. Faces 6 and 7, a nonzero slice, and levels
        // past the last one are all rejected.
        load_layout(14'd8192, 14'd8192, 14'd1, 14'd13, 14'd16, 14'd0,
                    CFG_DATA_W'(KIND_CUBE), 1'b0);
        send_query(4'd0, 3'd0, 11'd0);
        send_query(4'd0, 3'd5, 11'd0);
        send_query(4'd13, 3'd5, 11'd0);
        send_query(4'd7, 3'd3, 11'd0);
        send_query(4'd0, 3'd6, 11'd0);
        send_query(4'd0, 3'd7, 11'd0);
        send_query(4'd0, 3'd2, 11'd1);
        send_query(4'd14, 3'd0, 11'd0);
        drain_queries();

        // Compressed volume with a zero base width (read as one), a last level of 15
        // that clamps to 13, and the widest element size. Slices run up to the level
        // depth minus one; the depth itself is out of range.
        load_layout(14'd0, 14'd37, 14'd2048, 14'd15, 14'd31, 14'd1,
                    CFG_DATA_W'(KIND_VOLUME), 1'b0);
        send_query(4'd0, 3'd0, 11'd2047);
        send_query(4'd1, 3'd0, 11'd1023);
        send_query(4'd1, 3'd0, 11'd1024);
        send_query(4'd13, 3'd0, 11'd0);
        send_query(4'd0, 3'd1, 11'd0);
        send_query(4'd15, 3'd0, 11'd0);
        drain_queries();

        // The unnamed target kind behaves as flat. With every size at its field maximum
        // the byte sizes of the levels and the total saturate at the top of the range.
        load_layout(14'd16383, 14'd16383, 14'd4095, 14'd13, 14'd31, 14'd0,
                    CFG_DATA_W'(KIND_SPARE), 1'b0);
        send_query(4'd0, 3'd0, 11'd0);
        send_query(4'd13, 3'd0, 11'd0);
        send_query(4'd5, 3'd0, 11'd0);
        send_query(4'd0, 3'd1, 11'd0);
        send_query(4'd0, 3'd0, 11'd2047);

        // Random phases. The first three use fixed extreme layouts: the smallest
        // possible texture, the largest compressed volume, and the largest cube.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_queries();
            idle_pct = (phase == QUIET_PHASE) ? 0 : IDLE_PCT;
            if (phase == 0)
                load_layout(14'd1, 14'd1, 14'd1, 14'd0, 14'd1, 14'd0,
                            CFG_DATA_W'(KIND_FLAT), 1'b0);
            else if (phase == 1)
                load_layout(14'd16383, 14'd16383, 14'd4095, 14'd15, 14'd31, 14'd1,
                            CFG_DATA_W'(KIND_VOLUME), 1'b1);
            else if (phase == 2)
                load_layout(14'd16383, 14'd16383, 14'd1, 14'd13, 14'd31, 14'd0,
                            CFG_DATA_W'(KIND_CUBE), 1'b0);
            else
                random_layout();
            repeat (PHASE_ITEMS)
                random_query();
        end

        // Let any stray extra result show up before the verdict.
        drain_queries();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: a correct run needs only a small fraction of this.
    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
rtl/mlo_pkg.sv
rtl/mlo_cfg_regs.sv
rtl/mlo_sat_mul.sv
rtl/mlo_walker.sv
rtl/mipmap_layout_offset_calc.sv
tb/mipmap_layout_offset_calc_checker.sv
tb/mipmap_layout_offset_calc_tb.sv
